@@ hw/rtl/adf_pkg.sv @@
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types, constants and helper functions for the auto-ranging decimal
// formatter: thresholds, divider constants, character codes, control struct.
// ----------------------------------------------------------------------------
package adf_pkg;

  // Input value width and configuration port geometry
  localparam int VALUE_BITS = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FULL_UNIT   = CFG_IDX_W'(1);

  // Digit count codes
  localparam logic [2:0] DC_THREE = 3'd3;
  localparam logic [2:0] DC_FOUR  = 3'd4;
  localparam logic [2:0] DC_RESET = DC_THREE;

  // Range thresholds in micro-units
  localparam logic signed [VALUE_BITS-1:0] TH_0_995  = VALUE_BITS'(995000);
  localparam logic signed [VALUE_BITS-1:0] TH_9_995  = VALUE_BITS'(9995000);
  localparam logic signed [VALUE_BITS-1:0] TH_99_95  = VALUE_BITS'(99950000);
  localparam logic signed [VALUE_BITS-1:0] TH_999_5  = VALUE_BITS'(999500000);

  // Datapath widths
  localparam int MAG_BITS    = VALUE_BITS;          // |v| up to 2^31
  localparam int MIN_SHIFT   = 3;                   // divisor 10^3 = 2^3 * 5^3
  localparam int X_BITS      = MAG_BITS - MIN_SHIFT;
  localparam int RECIP_BITS  = 26;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = X_BITS + RECIP_BITS;
  localparam int Q_BITS      = PROD_W - RECIP_SHIFT;
  localparam int POW5_BITS   = 14;
  localparam int P2_W        = Q_BITS + POW5_BITS;

  // Binary to BCD conversion
  localparam int BCD_DIGITS = 7;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = 6;
  localparam int BIN_BITS   = DD_STAGES * DD_STEPS;
  localparam int DD_W       = BCD_W + BIN_BITS;

  // Output string
  localparam int STR_LEN = 8;
  localparam int IDX_W   = $clog2(STR_LEN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int CHAR_W  = 7;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
  localparam logic [CHAR_W-1:0] CH_R     = 7'h72;

  // Rounding divisor select
  typedef enum logic [1:0] {
    DSEL_1E3,
    DSEL_1E4,
    DSEL_1E5,
    DSEL_1E6
  } dsel_t;

  // Per-item format control, travels with the data
  typedef struct packed {
    logic       err;
    logic       sgn;
    logic [1:0] frac;
    logic [2:0] wid;
    dsel_t      dsel;
  } fmt_ctl_t;

  // Half of the divisor, the rounding bias
  function automatic logic [MAG_BITS-1:0] half_of(input dsel_t d);
    case (d)
      DSEL_1E3: half_of = MAG_BITS'(500);
      DSEL_1E4: half_of = MAG_BITS'(5000);
      DSEL_1E5: half_of = MAG_BITS'(50000);
      DSEL_1E6: half_of = MAG_BITS'(500000);
      default:  half_of = '0;
    endcase
  endfunction

  // floor(2^32 / 5^k); quotient estimate is exact or one low
  function automatic logic [RECIP_BITS-1:0] recip_of(input dsel_t d);
    case (d)
      DSEL_1E3: recip_of = RECIP_BITS'(34359738);
      DSEL_1E4: recip_of = RECIP_BITS'(6871947);
      DSEL_1E5: recip_of = RECIP_BITS'(1374389);
      DSEL_1E6: recip_of = RECIP_BITS'(274877);
      default:  recip_of = '0;
    endcase
  endfunction

  // 5^k for the remainder correction
  function automatic logic [POW5_BITS-1:0] pow5_of(input dsel_t d);
    case (d)
      DSEL_1E3: pow5_of = POW5_BITS'(125);
      DSEL_1E4: pow5_of = POW5_BITS'(625);
      DSEL_1E5: pow5_of = POW5_BITS'(3125);
      DSEL_1E6: pow5_of = POW5_BITS'(15625);
      default:  pow5_of = POW5_BITS'(1);
    endcase
  endfunction

endpackage

@@ hw/rtl/adf_front.sv @@
// ----------------------------------------------------------------------------
// adf_front
// Range selection, sign/magnitude split, rounding bias and the 2^k part of
// the decimal divide. Two register stages.
// ----------------------------------------------------------------------------
module adf_front import adf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [2:0]                   digit_count,
  input  logic                         full_unit,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [X_BITS-1:0]            out_x,
  output fmt_ctl_t                     out_ctl
);

  logic                a_vld_r;
  logic [MAG_BITS-1:0] a_mag_r;
  fmt_ctl_t            a_ctl_r;
  logic                b_vld_r;
  logic [X_BITS-1:0]   b_x_r;
  fmt_ctl_t            b_ctl_r;

  logic                a_load, b_load;
  fmt_ctl_t            a_ctl_nxt;
  logic [MAG_BITS-1:0] a_mag_nxt;
  logic [MAG_BITS-1:0] b_sum;
  logic [X_BITS-1:0]   b_x_nxt;

  assign b_load = !b_vld_r || out_rdy;
  assign a_load = !a_vld_r || b_load;
  assign in_rdy = a_load;

  // Stage A: pick range and take magnitude
  always_comb begin
    a_ctl_nxt      = '0;
    a_ctl_nxt.sgn  = in_value[VALUE_BITS-1];
    a_mag_nxt      = a_ctl_nxt.sgn ? (~in_value + MAG_BITS'(1)) : in_value;
    case (digit_count)
      DC_THREE: begin
        if (in_value >= TH_99_95) begin
          a_ctl_nxt.dsel = DSEL_1E6; a_ctl_nxt.frac = 2'd0; a_ctl_nxt.wid = 3'd3;
        end else if (in_value >= TH_9_995) begin
          a_ctl_nxt.dsel = DSEL_1E5; a_ctl_nxt.frac = 2'd1; a_ctl_nxt.wid = 3'd2;
        end else if (full_unit || in_value >= TH_0_995) begin
          a_ctl_nxt.dsel = DSEL_1E4; a_ctl_nxt.frac = 2'd2; a_ctl_nxt.wid = 3'd1;
        end else begin
          a_ctl_nxt.dsel = DSEL_1E3; a_ctl_nxt.frac = 2'd0; a_ctl_nxt.wid = 3'd3;
        end
      end
      DC_FOUR: begin
        if (in_value >= TH_999_5) begin
          a_ctl_nxt.dsel = DSEL_1E6; a_ctl_nxt.frac = 2'd0; a_ctl_nxt.wid = 3'd4;
        end else if (in_value >= TH_99_95) begin
          a_ctl_nxt.dsel = DSEL_1E5; a_ctl_nxt.frac = 2'd1; a_ctl_nxt.wid = 3'd3;
        end else if (full_unit || in_value >= TH_0_995) begin
          a_ctl_nxt.dsel = DSEL_1E4; a_ctl_nxt.frac = 2'd2; a_ctl_nxt.wid = 3'd2;
        end else begin
          a_ctl_nxt.dsel = DSEL_1E3; a_ctl_nxt.frac = 2'd0; a_ctl_nxt.wid = 3'd4;
        end
      end
      default: begin
        a_ctl_nxt.err = 1'b1;
      end
    endcase
  end

  // Stage B: add half divisor, shift out the 2^k factor
  always_comb begin
    b_sum = a_mag_r + half_of(a_ctl_r.dsel);
    case (a_ctl_r.dsel)
      DSEL_1E3: b_x_nxt = b_sum[MAG_BITS-1:3];
      DSEL_1E4: b_x_nxt = {1'b0, b_sum[MAG_BITS-1:4]};
      DSEL_1E5: b_x_nxt = {2'b0, b_sum[MAG_BITS-1:5]};
      DSEL_1E6: b_x_nxt = {3'b0, b_sum[MAG_BITS-1:6]};
      default:  b_x_nxt = '0;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_load) a_vld_r <= in_vld;
      if (b_load) b_vld_r <= a_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_load && in_vld) begin
      a_mag_r <= a_mag_nxt;
      a_ctl_r <= a_ctl_nxt;
    end
    if (b_load && a_vld_r) begin
      b_x_r   <= b_x_nxt;
      b_ctl_r <= a_ctl_r;
    end
  end

  assign out_vld = b_vld_r;
  assign out_x   = b_x_r;
  assign out_ctl = b_ctl_r;

endmodule

@@ hw/rtl/adf_div.sv @@
// ----------------------------------------------------------------------------
// adf_div
// Divide by 5^k through a reciprocal multiply, then one remainder check to
// fix the estimate. Three register stages.
// ----------------------------------------------------------------------------
module adf_div import adf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [X_BITS-1:0] in_x,
  input  fmt_ctl_t          in_ctl,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [Q_BITS-1:0] out_q,
  output fmt_ctl_t          out_ctl
);

  logic              c_vld_r, d_vld_r, e_vld_r;
  logic [X_BITS-1:0] c_x_r, d_x_r;
  logic [Q_BITS-1:0] c_q0_r, d_q0_r, e_q_r;
  logic [X_BITS-1:0] d_p2_r;
  fmt_ctl_t          c_ctl_r, d_ctl_r, e_ctl_r;

  logic              c_load, d_load, e_load;
  logic [PROD_W-1:0] c_prod;
  logic [P2_W-1:0]   d_prod;
  logic [X_BITS-1:0] e_rem;
  logic              e_bump;

  assign e_load = !e_vld_r || out_rdy;
  assign d_load = !d_vld_r || e_load;
  assign c_load = !c_vld_r || d_load;
  assign in_rdy = c_load;

  // Quotient estimate, then q0 * 5^k, then remainder check
  assign c_prod = PROD_W'(in_x) * PROD_W'(recip_of(in_ctl.dsel));
  assign d_prod = P2_W'(c_q0_r) * P2_W'(pow5_of(c_ctl_r.dsel));
  assign e_rem  = d_x_r - d_p2_r;
  assign e_bump = e_rem >= X_BITS'(pow5_of(d_ctl_r.dsel));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      if (c_load) c_vld_r <= in_vld;
      if (d_load) d_vld_r <= c_vld_r;
      if (e_load) e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load && in_vld) begin
      c_x_r   <= in_x;
      c_q0_r  <= c_prod[PROD_W-1:RECIP_SHIFT];
      c_ctl_r <= in_ctl;
    end
    if (d_load && c_vld_r) begin
      d_x_r   <= c_x_r;
      d_q0_r  <= c_q0_r;
      d_p2_r  <= d_prod[X_BITS-1:0];
      d_ctl_r <= c_ctl_r;
    end
    if (e_load && d_vld_r) begin
      e_q_r   <= d_q0_r + Q_BITS'(e_bump);
      e_ctl_r <= d_ctl_r;
    end
  end

  assign out_vld = e_vld_r;
  assign out_q   = e_q_r;
  assign out_ctl = e_ctl_r;

endmodule

@@ hw/rtl/adf_bcd.sv @@
// ----------------------------------------------------------------------------
// adf_bcd
// Binary to BCD by shift-and-add-3, a fixed number of shift steps per
// register stage.
// ----------------------------------------------------------------------------
module adf_bcd import adf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [Q_BITS-1:0] in_q,
  input  fmt_ctl_t          in_ctl,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [BCD_W-1:0]  out_bcd,
  output fmt_ctl_t          out_ctl
);

  // A group of shift steps on {bcd, remaining binary}
  function automatic logic [DD_W-1:0] dd_run(input logic [DD_W-1:0] s_in);
    logic [DD_W-1:0] s;
    s = s_in;
    for (int n = 0; n < DD_STEPS; n++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (s[BIN_BITS+4*d +: 4] >= 4'd5) begin
          s[BIN_BITS+4*d +: 4] = s[BIN_BITS+4*d +: 4] + 4'd3;
        end
      end
      s = {s[DD_W-2:0], 1'b0};
    end
    return s;
  endfunction

  logic            vld_r [DD_STAGES];
  logic            load  [DD_STAGES];
  logic [DD_W-1:0] sh_r  [DD_STAGES];
  fmt_ctl_t        ctl_r [DD_STAGES];

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_stage
    logic            vld_src;
    logic [DD_W-1:0] sh_src;
    fmt_ctl_t        ctl_src;
    logic            dn_rdy;

    // Source of this stage
    if (g == 0) begin : g_first
      assign vld_src = in_vld;
      assign sh_src  = {{BCD_W{1'b0}}, BIN_BITS'(in_q)};
      assign ctl_src = in_ctl;
    end else begin : g_next
      assign vld_src = vld_r[g-1];
      assign sh_src  = sh_r[g-1];
      assign ctl_src = ctl_r[g-1];
    end

    if (g == DD_STAGES - 1) begin : g_last
      assign dn_rdy = out_rdy;
    end else begin : g_mid
      assign dn_rdy = load[g+1];
    end

    assign load[g] = !vld_r[g] || dn_rdy;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (load[g]) begin
        vld_r[g] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (load[g] && vld_src) begin
        sh_r[g]  <= dd_run(sh_src);
        ctl_r[g] <= ctl_src;
      end
    end
  end

  assign in_rdy  = load[0];
  assign out_vld = vld_r[DD_STAGES-1];
  assign out_bcd = sh_r[DD_STAGES-1][DD_W-1 -: BCD_W];
  assign out_ctl = ctl_r[DD_STAGES-1];

endmodule

@@ hw/rtl/adf_emit.sv @@
// ----------------------------------------------------------------------------
// adf_emit
// Lays the digits out as a right-aligned string (padding, sign, point) and
// shifts it out one character per request.
// ----------------------------------------------------------------------------
module adf_emit import adf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [BCD_W-1:0]  in_bcd,
  input  fmt_ctl_t          in_ctl,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic              vld_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CHAR_W-1:0] buf_r [STR_LEN];

  logic [3:0]        dig [STR_LEN];
  logic              neg;
  logic [2:0]        nd;
  logic [1:0]        fl;
  logic [LEN_W-1:0]  sig_len, lead, len, start_full;
  logic [IDX_W-1:0]  start, idx_nxt;
  logic [CHAR_W-1:0] chr [STR_LEN];
  logic              take, at_end;

  // Digits, sign and field lengths
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dig[i] = in_bcd[4*i +: 4];
    end
    for (int i = BCD_DIGITS; i < STR_LEN; i++) begin
      dig[i] = 4'd0;
    end
    neg = in_ctl.sgn && (in_bcd != '0);
    nd  = 3'd1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (i >= int'(in_ctl.frac) && dig[i] != 4'd0) begin
        nd = 3'(i - int'(in_ctl.frac) + 1);
      end
    end
    fl      = (in_ctl.frac == 2'd0) ? 2'd0 : in_ctl.frac + 2'd1;
    sig_len = LEN_W'(nd) + LEN_W'(neg);
    lead    = (LEN_W'(in_ctl.wid) > sig_len) ? LEN_W'(in_ctl.wid) : sig_len;
    len     = in_ctl.err ? LEN_W'(3) : lead + LEN_W'(fl);
    start_full = LEN_W'(STR_LEN) - len;
    start      = start_full[IDX_W-1:0];
  end

  // Right-aligned character slots; e counts from the string end
  always_comb begin
    int e, t, di;
    for (int j = 0; j < STR_LEN; j++) begin
      e  = STR_LEN - 1 - j;
      t  = e - int'(fl);
      di = (in_ctl.frac == 2'd0) ? e : e - 1;
      if (in_ctl.err) begin
        if (j == STR_LEN - 3)     chr[j] = CH_E;
        else if (j > STR_LEN - 3) chr[j] = CH_R;
        else                      chr[j] = CH_SPACE;
      end else if (e < int'(in_ctl.frac)) begin
        chr[j] = CH_ZERO | {3'b000, dig[e]};
      end else if (in_ctl.frac != 2'd0 && e == int'(in_ctl.frac)) begin
        chr[j] = CH_DOT;
      end else if (t < int'(nd)) begin
        chr[j] = CH_ZERO | {3'b000, dig[di]};
      end else if (t == int'(nd) && neg) begin
        chr[j] = CH_MINUS;
      end else begin
        chr[j] = CH_SPACE;
      end
    end
  end

  // Shift-out control: next string loads as the last character leaves
  assign at_end = idx_r == IDX_W'(STR_LEN - 1);
  assign take   = !vld_r || (out_rdy && at_end);
  assign in_rdy = take;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      if (in_vld) idx_nxt = start;
    end else if (out_rdy) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (take) vld_r <= in_vld;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_vld) begin
      for (int j = 0; j < STR_LEN; j++) buf_r[j] <= chr[j];
    end
  end

  assign out_vld  = vld_r;
  assign out_char = buf_r[idx_r];
  assign out_last = at_end;

endmodule

@@ hw/rtl/autorange_decimal_formatter_core.sv @@
// ----------------------------------------------------------------------------
// autorange_decimal_formatter_core
// Formats a signed micro-unit measurement as an auto-ranged ASCII display
// string, one character per output request.
// ----------------------------------------------------------------------------
// A new measurement can be accepted every cycle while in_ready is high, into
// a ten-stage pipeline (range select, rounding, reciprocal divide, BCD
// conversion, string build); it passes the front, divider and BCD stages
// before the string buffer presents its first character. Strings leave
// through a single character port, one character per cycle while out_ready
// is high, so sustained throughput is one measurement per string (3 to 8
// characters); the next string is loaded in the cycle its predecessor's last
// character is taken. Configuration writes take effect for requests accepted
// after the write and should be made while the block is idle.
// ----------------------------------------------------------------------------
module autorange_decimal_formatter_core import adf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value_micro,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHAR_W-1:0]            out_char_code,
  output logic                         out_last_char,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wr_data
);

  logic [2:0] digit_count_r;
  logic       full_unit_r;

  logic              f_vld, f_rdy;
  logic [X_BITS-1:0] f_x;
  fmt_ctl_t          f_ctl;
  logic              d_vld, d_rdy;
  logic [Q_BITS-1:0] d_q;
  fmt_ctl_t          d_ctl;
  logic              b_vld, b_rdy;
  logic [BCD_W-1:0]  b_bcd;
  fmt_ctl_t          b_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= DC_RESET;
      full_unit_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIGIT_COUNT: digit_count_r <= cfg_wr_data[2:0];
        REG_FULL_UNIT:   full_unit_r   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  adf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_valid),
    .in_rdy      (in_ready),
    .in_value    (in_value_micro),
    .digit_count (digit_count_r),
    .full_unit   (full_unit_r),
    .out_vld     (f_vld),
    .out_rdy     (f_rdy),
    .out_x       (f_x),
    .out_ctl     (f_ctl)
  );

  adf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_rdy  (f_rdy),
    .in_x    (f_x),
    .in_ctl  (f_ctl),
    .out_vld (d_vld),
    .out_rdy (d_rdy),
    .out_q   (d_q),
    .out_ctl (d_ctl)
  );

  adf_bcd u_bcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld),
    .in_rdy  (d_rdy),
    .in_q    (d_q),
    .in_ctl  (d_ctl),
    .out_vld (b_vld),
    .out_rdy (b_rdy),
    .out_bcd (b_bcd),
    .out_ctl (b_ctl)
  );

  adf_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (b_vld),
    .in_rdy   (b_rdy),
    .in_bcd   (b_bcd),
    .in_ctl   (b_ctl),
    .out_vld  (out_valid),
    .out_rdy  (out_ready),
    .out_char (out_char_code),
    .out_last (out_last_char)
  );

endmodule

@@ hw/rtl/adf_checker.sv @@
// ----------------------------------------------------------------------------
// adf_checker
// Port-level checks on the formatter's character stream, bound to the top.
// ----------------------------------------------------------------------------
module adf_checker import adf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last_char
);

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled output changed");

  // Only display characters are produced
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CH_SPACE) || (out_char_code == CH_MINUS) ||
                  (out_char_code == CH_DOT) || (out_char_code == CH_E) ||
                  (out_char_code == CH_R) ||
                  ((out_char_code >= CH_ZERO) && (out_char_code <= CH_NINE)))
    else $error("unexpected character code");

  // A decimal point always has fraction digits after it
  a_dot_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == CH_DOT) |-> !out_last_char)
    else $error("string ends in a decimal point");

  // The error string continues after its 'E'
  a_err_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_char_code == CH_E) |=>
      out_valid && (out_char_code == CH_R))
    else $error("'E' not followed by 'r'");

endmodule

bind autorange_decimal_formatter_core adf_checker u_adf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char_code  (out_char_code),
  .out_last_char  (out_last_char)
);

@@ bench/tb_autorange_decimal_formatter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autorange_decimal_formatter_core
// Self-checking bench for the auto-ranging decimal formatter. A queue-fed
// driver offers micro-unit readings, a monitor predicts the display string of
// every accepted request and checks each character that leaves the block.
// Runs go through several digit-count / full-unit settings, including the
// invalid widths, with random stalls on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_autorange_decimal_formatter_core;
  import adf_pkg::*;

  // One expected character of a display string
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  localparam int  LONG_HOLD    = 200;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  NUM_PHASES   = 8;

  // Per-phase settings: digit count, full-unit mode, number of readings
  localparam logic [2:0] PHASE_DC [0:NUM_PHASES-1] =
    '{DC_FOUR, 3'd0, DC_THREE, DC_FOUR, 3'd7, DC_THREE, 3'd6, DC_FOUR};
  localparam bit PHASE_FULL [0:NUM_PHASES-1] = '{0, 0, 1, 1, 1, 0, 0, 0};
  localparam int PHASE_ITEMS [0:NUM_PHASES-1] = '{70, 15, 70, 70, 15, 70, 10, 80};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_value_micro = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [CHAR_W-1:0]            out_char_code;
  logic                         out_last_char;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wr_data = '0;

  // Shadow copy of the configuration
  logic [2:0] cur_digits = DC_RESET;
  logic       cur_full_unit = 1'b0;

  logic signed [VALUE_BITS-1:0] pending_readings[$];
  glyph_t                       expected_glyphs[$];
  logic [CHAR_W-1:0]            text_buf[$];

  int  mismatch_count = 0;
  bit  idle_on = 1'b1;
  bit  req_taken = 1'b0;
  int  tx_gap = 0;
  int  rx_hold = 0;
  int  stall_asks = 0;
  int  stall_seen = 0;

  autorange_decimal_formatter_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value_micro (in_value_micro),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Rounded fixed-point number: sign, integer part padded to width, fraction
  task automatic emit_fixed(input longint v, input longint unsigned div,
                            input int width, input int frac);
    longint unsigned   mag, q, ip, fp, scale;
    bit                neg;
    int                nd, i;
    logic [CHAR_W-1:0] dig [0:23];
    mag   = (v < 0) ? longint'(-v) : longint'(v);
    q     = (mag + div / 2) / div;
    neg   = (v < 0) && (q != 0);
    scale = (frac == 2) ? 100 : (frac == 1) ? 10 : 1;
    ip    = q / scale;
    fp    = q % scale;
    nd    = 0;
    do begin
      dig[nd] = CH_ZERO + CHAR_W'(ip % 10);
      nd++;
      ip = ip / 10;
    end while (ip != 0);
    for (i = nd + int'(neg); i < width; i++) text_buf.push_back(CH_SPACE);
    if (neg) text_buf.push_back(CH_MINUS);
    for (i = nd - 1; i >= 0; i--) text_buf.push_back(dig[i]);
    if (frac > 0) begin
      text_buf.push_back(CH_DOT);
      if (frac == 2) begin
        text_buf.push_back(CH_ZERO + CHAR_W'(fp / 10));
        text_buf.push_back(CH_ZERO + CHAR_W'(fp % 10));
      end else begin
        text_buf.push_back(CH_ZERO + CHAR_W'(fp));
      end
    end
  endtask

  // Display string of one reading under the current settings
  task automatic render_reading(input logic signed [VALUE_BITS-1:0] v);
    int n;
    text_buf.delete();
    if (cur_digits == DC_THREE) begin
      if (v >= TH_99_95) emit_fixed(v, 1000000, 3, 0);
      else if (v >= TH_9_995) emit_fixed(v, 100000, 2, 1);
      else if (cur_full_unit || v >= TH_0_995) emit_fixed(v, 10000, 1, 2);
      else emit_fixed(v, 1000, 3, 0);
    end else if (cur_digits == DC_FOUR) begin
      if (v >= TH_999_5) emit_fixed(v, 1000000, 4, 0);
      else if (v >= TH_99_95) emit_fixed(v, 100000, 3, 1);
      else if (cur_full_unit || v >= TH_0_995) emit_fixed(v, 10000, 2, 2);
      else emit_fixed(v, 1000, 4, 0);
    end else begin
      text_buf.push_back(CH_E);
      text_buf.push_back(CH_R);
      text_buf.push_back(CH_R);
    end
    n = (text_buf.size() > STR_LEN) ? STR_LEN : text_buf.size();
    for (int k = 0; k < n; k++)
      expected_glyphs.push_back('{code: text_buf[k], last: (k == n - 1)});
  endtask

  // Request side: predict on acceptance
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) render_reading(in_value_micro);
  end

  // Request driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (in_valid && !req_taken) begin
      // hold the request until it is taken
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (idle_on && pending_readings.size() != 0 && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      tx_gap   <= $urandom_range(0, 11);
    end else if (pending_readings.size() != 0) begin
      in_valid       <= 1'b1;
      in_value_micro <= pending_readings.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Character receiver with random stalls and the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (stall_asks != stall_seen) begin
      stall_seen <= stall_asks;
      rx_hold    <= LONG_HOLD;
      out_ready  <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold   <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Character checker
  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_glyphs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected char expected none, actual code %h last %b",
                 $time, out_char_code, out_last_char);
      end else begin
        want = expected_glyphs.pop_front();
        if (out_char_code !== want.code) begin
          mismatch_count++;
          $display("%0t: char_code expected %h, actual %h", $time, want.code, out_char_code);
        end
        if (out_last_char !== want.last) begin
          mismatch_count++;
          $display("%0t: last_char expected %b, actual %b", $time, want.last, out_last_char);
        end
      end
    end
  end

  // Both registers, back to back, while the block is idle
  task automatic apply_settings(input logic [2:0] digits, input bit full);
    logic [CFG_DATA_W-1:0] full_word;
    full_word = {CFG_DATA_W'($urandom_range(0, 3)) << 1} | CFG_DATA_W'(full);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_DIGIT_COUNT;
    cfg_wr_data <= digits;
    @(negedge clk);
    cfg_index   <= REG_FULL_UNIT;
    cfg_wr_data <= full_word;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_digits    = digits;
    cur_full_unit = full_word[0];
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_readings.size() != 0 || in_valid || expected_glyphs.size() != 0);
  endtask

  // Random reading, weighted toward range thresholds and rounding edges
  function automatic logic signed [VALUE_BITS-1:0] pick_reading();
    longint v;
    longint unsigned div;
    int delta;
    delta = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 5))
      0: v = longint'(int'($urandom()));
      1: begin
        case ($urandom_range(0, 3))
          0: v = TH_0_995;
          1: v = TH_9_995;
          2: v = TH_99_95;
          default: v = TH_999_5;
        endcase
        v = v + int'($urandom_range(0, 20)) - 10;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: div = 1000;
          1: div = 10000;
          2: div = 100000;
          default: div = 1000000;
        endcase
        v = longint'($urandom_range(0, 2000)) * div + div / 2 + delta;
      end
      3: v = $urandom_range(0, 2000000);
      4: v = $urandom_range(0, 1200000000);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = -64'sd2147483648;
          2: v = 0;
          default: v = delta;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return VALUE_BITS'(v);
  endfunction

  // Stimulus and phase sequencing
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: range edges, rounding edges, sign handling, field extremes
    pending_readings.push_back(0);
    pending_readings.push_back(1);
    pending_readings.push_back(-1);
    pending_readings.push_back(499);
    pending_readings.push_back(500);
    pending_readings.push_back(-499);
    pending_readings.push_back(-500);
    pending_readings.push_back(994999);
    pending_readings.push_back(995000);
    pending_readings.push_back(-995000);
    pending_readings.push_back(9994999);
    pending_readings.push_back(9995000);
    pending_readings.push_back(99949999);
    pending_readings.push_back(99950000);
    pending_readings.push_back(999499999);
    pending_readings.push_back(999500000);
    pending_readings.push_back(32'sh7FFF_FFFF);
    pending_readings.push_back(32'sh8000_0000);
    pending_readings.push_back(-123456);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      apply_settings(PHASE_DC[p], PHASE_FULL[p]);
      if (p == 2) begin
        // full-unit mode: small negatives, one rounding to zero
        pending_readings.push_back(-50000);
        pending_readings.push_back(-5000);
        pending_readings.push_back(-4999);
        stall_asks++;
      end
      for (int i = 0; i < PHASE_ITEMS[p]; i++) pending_readings.push_back(pick_reading());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_glyphs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/adf_pkg.sv
hw/rtl/adf_front.sv
hw/rtl/adf_div.sv
hw/rtl/adf_bcd.sv
hw/rtl/adf_emit.sv
hw/rtl/autorange_decimal_formatter_core.sv
hw/rtl/adf_checker.sv
bench/tb_autorange_decimal_formatter_core.sv
